@@ sv/krt_pkg.sv @@
// Shared types and codes for the keyed record table.
package krt_pkg;

    localparam int KEY_W  = 32;
    localparam int QTY_W  = 32;
    localparam int NAME_W = 64;
    localparam int LAST_W = 8;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EXISTS   = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]              opcode;
        logic signed [KEY_W-1:0] part_key;
        logic signed [QTY_W-1:0] quantity_value;
        logic [NAME_W-1:0]       name_bytes_low;
        logic [NAME_W-1:0]       name_bytes_mid;
        logic [NAME_W-1:0]       name_bytes_high;
        logic [LAST_W-1:0]       name_byte_last;
    } t_krt_in;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [QTY_W-1:0] found_quantity;
        logic [NAME_W-1:0]       found_name_low;
        logic [NAME_W-1:0]       found_name_mid;
        logic [NAME_W-1:0]       found_name_high;
        logic [LAST_W-1:0]       found_name_last;
    } t_krt_out;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       scan_step;
        logic       rec_read;
        logic       ins_write;
        logic       qty_write;
        logic       respond;
        logic       with_data;
        logic [1:0] status;
    } t_krt_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic hit;
        logic miss;
    } t_krt_stat;

endpackage

@@ sv/krt_datapath.sv @@
// Record storage, key scan, saturating update and result register.
module krt_datapath
    import krt_pkg::*;
#(
    parameter int TABLE_DEPTH = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_krt_in   i_item,
    input  t_krt_cmd  i_cmd,
    output t_krt_stat o_stat,
    output t_krt_out  o_result
);

    localparam int IdxW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CountW = $clog2(TABLE_DEPTH + 1);

    logic [KEY_W-1:0]  key_mem  [TABLE_DEPTH];
    logic [QTY_W-1:0]  qty_mem  [TABLE_DEPTH];
    logic [NAME_W-1:0] low_mem  [TABLE_DEPTH];
    logic [NAME_W-1:0] mid_mem  [TABLE_DEPTH];
    logic [NAME_W-1:0] high_mem [TABLE_DEPTH];
    logic [LAST_W-1:0] last_mem [TABLE_DEPTH];

    t_krt_in           r_in;
    t_krt_out          r_res;
    logic [CountW-1:0] r_count;
    logic [CountW-1:0] r_addr;
    logic              r_q_valid;
    logic [IdxW-1:0]   r_q_idx;
    logic [KEY_W-1:0]  r_key_q;
    logic [QTY_W-1:0]  r_qty_rd;
    logic [NAME_W-1:0] r_low_rd;
    logic [NAME_W-1:0] r_mid_rd;
    logic [NAME_W-1:0] r_high_rd;
    logic [LAST_W-1:0] r_last_rd;

    logic              scan_more;
    logic [IdxW-1:0]   ins_idx;
    logic [QTY_W:0]    sum;
    logic [QTY_W-1:0]  sat_qty;
    logic [IdxW-1:0]   qty_wr_idx;
    logic [QTY_W-1:0]  qty_wr_data;

    assign scan_more = (r_addr < r_count);
    assign ins_idx   = r_count[IdxW-1:0];

    // 33-bit sum; clamp when the two top bits disagree
    assign sum = {r_qty_rd[QTY_W-1], r_qty_rd}
               + {r_in.quantity_value[QTY_W-1], r_in.quantity_value};
    always_comb begin
        if (sum[QTY_W] != sum[QTY_W-1]) begin
            sat_qty = sum[QTY_W] ? {1'b1, {(QTY_W-1){1'b0}}} : {1'b0, {(QTY_W-1){1'b1}}};
        end else begin
            sat_qty = sum[QTY_W-1:0];
        end
    end

    assign qty_wr_idx  = i_cmd.qty_write ? r_q_idx : ins_idx;
    assign qty_wr_data = i_cmd.qty_write ? sat_qty : r_in.quantity_value;

    assign o_stat.full = (r_count == CountW'(TABLE_DEPTH));
    assign o_stat.hit  = r_q_valid && (r_key_q == r_in.part_key);
    assign o_stat.miss = !r_q_valid && (r_addr == r_count);

    // key memory: one read per scan step
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_write) begin
            key_mem[ins_idx] <= r_in.part_key;
        end
        if (i_cmd.scan_step && scan_more) begin
            r_key_q <= key_mem[r_addr[IdxW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_write || i_cmd.qty_write) begin
            qty_mem[qty_wr_idx] <= qty_wr_data;
        end
        if (i_cmd.rec_read) begin
            r_qty_rd <= qty_mem[r_q_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_write) begin
            low_mem[ins_idx]  <= r_in.name_bytes_low;
            mid_mem[ins_idx]  <= r_in.name_bytes_mid;
            high_mem[ins_idx] <= r_in.name_bytes_high;
            last_mem[ins_idx] <= r_in.name_byte_last;
        end
        if (i_cmd.rec_read) begin
            r_low_rd  <= low_mem[r_q_idx];
            r_mid_rd  <= mid_mem[r_q_idx];
            r_high_rd <= high_mem[r_q_idx];
            r_last_rd <= last_mem[r_q_idx];
        end
    end

    // scan control and record count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_addr    <= '0;
            r_q_valid <= 1'b0;
        end else begin
            if (i_cmd.ins_write) begin
                r_count <= r_count + CountW'(1);
            end
            if (i_cmd.load) begin
                r_addr    <= '0;
                r_q_valid <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_q_valid <= scan_more;
                if (scan_more) begin
                    r_addr <= r_addr + CountW'(1);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_item;
        end
        if (i_cmd.scan_step && scan_more) begin
            r_q_idx <= r_addr[IdxW-1:0];
        end
        if (i_cmd.respond) begin
            r_res.status <= i_cmd.status;
            if (i_cmd.with_data) begin
                r_res.found_quantity  <= r_qty_rd;
                r_res.found_name_low  <= r_low_rd;
                r_res.found_name_mid  <= r_mid_rd;
                r_res.found_name_high <= r_high_rd;
                r_res.found_name_last <= r_last_rd;
            end else begin
                r_res.found_quantity  <= '0;
                r_res.found_name_low  <= '0;
                r_res.found_name_mid  <= '0;
                r_res.found_name_high <= '0;
                r_res.found_name_last <= '0;
            end
        end
    end

    assign o_result = r_res;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(TABLE_DEPTH))
        else $error("record count beyond table depth");

    a_ins_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_write |-> (r_count < CountW'(TABLE_DEPTH)))
        else $error("insert write into a full table");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_valid |-> (CountW'(r_q_idx) < r_count))
        else $error("scan compare on an unwritten entry");
`endif

endmodule

@@ sv/krt_ctrl.sv @@
// Operation sequencer for the keyed record table.
module krt_ctrl
    import krt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [1:0] i_opcode,
    input  t_krt_stat  i_stat,
    output t_krt_cmd   o_cmd,
    output logic       busy,
    output logic       o_done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_op, n_op;
    logic       r_done, n_done;
    t_krt_cmd   cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_op    = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op = i_opcode;
                    if (i_opcode == OP_INSERT && i_stat.full) begin
                        cmd.respond = 1'b1;
                        cmd.status  = ST_FULL;
                    end else if (i_opcode == OP_NONE) begin
                        cmd.respond = 1'b1;
                        cmd.status  = ST_OK;
                    end else begin
                        cmd.load = 1'b1;
                        n_state  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    if (r_op == OP_INSERT) begin
                        cmd.respond = 1'b1;
                        cmd.status  = ST_EXISTS;
                        n_state     = S_IDLE;
                    end else begin
                        cmd.rec_read = 1'b1;
                        n_state      = S_FINISH;
                    end
                end else if (i_stat.miss) begin
                    cmd.respond = 1'b1;
                    n_state     = S_IDLE;
                    if (r_op == OP_INSERT) begin
                        cmd.ins_write = 1'b1;
                        cmd.status    = ST_OK;
                    end else begin
                        cmd.status = ST_NOTFOUND;
                    end
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_FINISH: begin
                cmd.respond = 1'b1;
                cmd.status  = ST_OK;
                n_state     = S_IDLE;
                if (r_op == OP_UPDATE) begin
                    cmd.qty_write = 1'b1;
                end else begin
                    cmd.with_data = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_done = cmd.respond;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_NONE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_done  <= n_done;
        end
    end

    assign o_cmd  = cmd;
    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

`ifndef ASSERT_OFF
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || r_done))
        else $error("accepted word neither answered nor in progress");

    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(busy || start))
        else $error("result strobe without an operation");

    a_finish_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |-> ($past(i_stat.hit) && r_op != OP_INSERT))
        else $error("record fetch without a key match");
`endif

endmodule

@@ sv/keyed_record_table.sv @@
// Top level of the keyed record table: controller plus datapath.
//
// Usage: present an operation word on i_item and raise start; the word is
// taken at a clock edge where start is high and busy is low. Opcodes are
// insert, search, update quantity; the unused opcode answers ok at once.
// Every word yields exactly one result word on o_result, shown for one
// cycle with o_result_valid high. The receiver cannot hold results off.
// Insert into a full table and the unused opcode answer without a scan.
// Otherwise the key memory is scanned one entry per cycle from entry
// zero until the first match or the last stored record; search and
// update read the matched record back before answering. busy is low
// while the result strobe is shown, so the next word can be taken in
// that same cycle.
// Reset (synchronous, active low) empties the table; record storage itself
// is not cleared and holds nothing meaningful until written.
module keyed_record_table
    import krt_pkg::*;
#(
    parameter int TABLE_DEPTH = 128
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_krt_in  i_item,
    output logic     busy,
    output logic     o_result_valid,
    output t_krt_out o_result
);

    t_krt_cmd  cmd;
    t_krt_stat stat;

    krt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_item.opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_done   (o_result_valid)
    );

    krt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result)
    );

endmodule
